// File: src/jds_pkg.sv
// Shared types and constants for the joystick dead-zone scaler.
`default_nettype none

package jds_pkg;

  // Field widths
  localparam int unsigned SampleW          = 12;
  localparam int unsigned SampleBitsDefault = 12;
  localparam int unsigned CenterW          = 12;
  localparam int unsigned BandW            = 11;
  localparam int unsigned ScaleW           = 11;
  localparam int unsigned PosW             = 8;
  localparam int unsigned CfgDataW         = 12;

  // Mapping arithmetic
  localparam int unsigned OffsetW  = 12;               // v + full_scale, 0..4094
  localparam int unsigned DenW     = ScaleW + 1;       // 2 * full_scale
  localparam int unsigned NumW     = 20;               // offset * 200
  localparam int unsigned QuotBits = 8;                // quotient 0..200
  localparam int          DiffLimit = 2000;
  localparam int unsigned OutSpan   = 200;
  localparam int unsigned OutOffset = 100;

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    CfgXCenter   = 2'd0,
    CfgYCenter   = 2'd1,
    CfgDeadBand  = 2'd2,
    CfgFullScale = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CenterW-1:0] x_center;
    logic [CenterW-1:0] y_center;
    logic [BandW-1:0]   dead_band;
    logic [ScaleW-1:0]  full_scale;
  } cfg_t;

  // One job handed from front to back: per-axis offsets and shared divisor.
  typedef struct packed {
    logic [OffsetW-1:0] y_off;
    logic [OffsetW-1:0] x_off;
    logic [DenW-1:0]    den;
  } job_t;

endpackage

`default_nettype wire

// File: src/jds_front.sv
// Front end: accepts sample pairs, centers, clamps and applies the dead zone.
`default_nettype none

module jds_front #(
  parameter int unsigned SAMPLE_BITS = jds_pkg::SampleBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire jds_pkg::cfg_t                cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [jds_pkg::SampleW-1:0]  x_sample_i,
  input  wire logic [jds_pkg::SampleW-1:0]  y_sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output jds_pkg::job_t                     out_job_o
);
  import jds_pkg::*;

  localparam logic [SampleW-1:0] SampleMask = (SAMPLE_BITS >= SampleW) ?
      {SampleW{1'b1}} : SampleW'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam int unsigned WorkW = 14;

  // Returns v + fs where v is the clamped, inverted, dead-zoned deflection.
  function automatic logic [OffsetW-1:0] axis_offset(
    input logic [SampleW-1:0] sample,
    input logic [CenterW-1:0] center,
    input logic [BandW-1:0]   band,
    input logic [ScaleW-1:0]  fs
  );
    logic signed [WorkW-1:0] diff;
    logic signed [WorkW-1:0] v;
    logic signed [WorkW-1:0] db;
    logic signed [WorkW-1:0] fss;
    begin
      db   = $signed(WorkW'(band));
      fss  = $signed(WorkW'(fs));
      diff = $signed(WorkW'(sample)) - $signed(WorkW'(center));
      if (diff > WorkW'(DiffLimit)) begin
        diff = WorkW'(DiffLimit);
      end else if (diff < -$signed(WorkW'(DiffLimit))) begin
        diff = -$signed(WorkW'(DiffLimit));
      end
      v = -diff;
      if (v > db) begin
        v = v - db;
      end else if (v < -db) begin
        v = v + db;
      end else begin
        v = '0;
      end
      if (v > fss) begin
        v = fss;
      end else if (v < -fss) begin
        v = -fss;
      end
      axis_offset = OffsetW'(v + fss);
    end
  endfunction

  logic [ScaleW-1:0] fs_eff;
  job_t              job_d, job_q;
  logic              valid_q;
  logic              take;

  assign fs_eff = (cfg_i.full_scale == '0) ? ScaleW'(1) : cfg_i.full_scale;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    job_d.x_off = axis_offset(x_sample_i & SampleMask, cfg_i.x_center,
                              cfg_i.dead_band, fs_eff);
    job_d.y_off = axis_offset(y_sample_i & SampleMask, cfg_i.y_center,
                              cfg_i.dead_band, fs_eff);
    job_d.den   = {fs_eff, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_job_o   = job_q;

endmodule

`default_nettype wire

// File: src/jds_queue.sv
// Small job queue decoupling the front end from the divider back end.
`default_nettype none

module jds_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire jds_pkg::job_t wr_job_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output jds_pkg::job_t      rd_job_o
);
  import jds_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

`default_nettype wire

// File: src/jds_back.sv
// Back end: scales by 200 and divides by 2*full_scale, one quotient bit per stage.
`default_nettype none

module jds_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire jds_pkg::job_t             in_job_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [jds_pkg::PosW-1:0] x_pos_o,
  output logic signed [jds_pkg::PosW-1:0] y_pos_o
);
  import jds_pkg::*;

  // Stage 0 holds the scaled dividend; stages 1..QuotBits each resolve one bit.
  localparam int unsigned NStages = QuotBits + 1;
  localparam int unsigned Last    = NStages - 1;

  logic [NStages-1:0]  valid_q;
  logic [NumW-1:0]     xrem_q [NStages];
  logic [NumW-1:0]     yrem_q [NStages];
  logic [DenW-1:0]     den_q  [NStages];
  logic [QuotBits-1:0] xquo_q [NStages];
  logic [QuotBits-1:0] yquo_q [NStages];

  logic [NumW-1:0]     xrem_d [NStages];
  logic [NumW-1:0]     yrem_d [NStages];
  logic [QuotBits-1:0] xquo_d [NStages];
  logic [QuotBits-1:0] yquo_d [NStages];
  logic [NumW-1:0]     trial  [NStages];
  logic                adv;

  assign adv        = !valid_q[Last] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    xrem_d[0] = NumW'(in_job_i.x_off) * NumW'(OutSpan);
    yrem_d[0] = NumW'(in_job_i.y_off) * NumW'(OutSpan);
    xquo_d[0] = '0;
    yquo_d[0] = '0;
    trial[0]  = '0;
    for (int k = 1; k < NStages; k++) begin
      trial[k]  = NumW'(den_q[k-1]) << (QuotBits - k);
      xrem_d[k] = xrem_q[k-1];
      yrem_d[k] = yrem_q[k-1];
      xquo_d[k] = xquo_q[k-1];
      yquo_d[k] = yquo_q[k-1];
      if (xrem_q[k-1] >= trial[k]) begin
        xrem_d[k] = xrem_q[k-1] - trial[k];
        xquo_d[k][QuotBits-k] = 1'b1;
      end
      if (yrem_q[k-1] >= trial[k]) begin
        yrem_d[k] = yrem_q[k-1] - trial[k];
        yquo_d[k][QuotBits-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Last-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q[0] <= in_job_i.den;
      for (int k = 0; k < NStages; k++) begin
        xrem_q[k] <= xrem_d[k];
        yrem_q[k] <= yrem_d[k];
        xquo_q[k] <= xquo_d[k];
        yquo_q[k] <= yquo_d[k];
      end
      for (int k = 1; k < NStages; k++) begin
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign out_valid_o = valid_q[Last];
  assign x_pos_o     = $signed(xquo_q[Last] - PosW'(OutOffset));
  assign y_pos_o     = $signed(yquo_q[Last] - PosW'(OutOffset));

endmodule

`default_nettype wire

// File: src/joystick_deadzone_scaler_core.sv
// Top level of the joystick dead-zone scaler: config registers and stream glue.
//
// Usage:
//   s_axis carries one X/Y raw sample pair per transaction; m_axis returns the
//   scaled pair (-100..100 per axis, sign inverted from raw) per transaction,
//   in order, one result per input.
//   The cfg port writes x_center, y_center, dead_band and full_scale by index;
//   write only while no transaction is in flight.
// Throughput: one transaction per cycle sustained while m_axis_tready is high.
// Path: the front register loads at the accepting edge, then the job passes
//   through the queue and 9 divider stages (scale by 200, then one quotient
//   bit per stage over 8 stages) before m_axis_tvalid rises.
// Stall: when m_axis_tready drops while a result waits, the divider pipeline
//   freezes; the front keeps accepting until the 4-entry queue and its own
//   register fill, then s_axis_tready falls.
// Reset: rst_ni (async, active low) empties the pipeline and queue and loads
//   x_center = y_center = 2047, dead_band = 200, full_scale = 1700.
// A full_scale of zero acts as one.
`default_nettype none

module joystick_deadzone_scaler_core #(
  parameter int unsigned SAMPLE_BITS = jds_pkg::SampleBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input samples
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [2*jds_pkg::SampleW-1:0] s_axis_tdata,  // x_sample, y_sample
  // Scaled positions
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [2*jds_pkg::PosW-1:0]         m_axis_tdata,  // x_pos, y_pos
  // Configuration writes
  input  wire logic                          cfg_we_i,
  input  wire jds_pkg::cfg_idx_e             cfg_idx_i,
  input  wire logic [jds_pkg::CfgDataW-1:0]  cfg_data_i
);
  import jds_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register writes; narrower registers keep the low bits.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgXCenter:   cfg_d.x_center   = cfg_data_i[CenterW-1:0];
        CfgYCenter:   cfg_d.y_center   = cfg_data_i[CenterW-1:0];
        CfgDeadBand:  cfg_d.dead_band  = cfg_data_i[BandW-1:0];
        CfgFullScale: cfg_d.full_scale = cfg_data_i[ScaleW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_center   <= CenterW'(2047);
      cfg_q.y_center   <= CenterW'(2047);
      cfg_q.dead_band  <= BandW'(200);
      cfg_q.full_scale <= ScaleW'(1700);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front -> queue -> back
  logic fr_valid, fr_ready;
  job_t fr_job;
  logic qu_valid, qu_ready;
  job_t qu_job;
  logic signed [PosW-1:0] x_pos, y_pos;

  jds_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .x_sample_i  (s_axis_tdata[SampleW-1:0]),
    .y_sample_i  (s_axis_tdata[2*SampleW-1:SampleW]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_job_o   (fr_job)
  );

  jds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_job_i   (fr_job),
    .rd_valid_o (qu_valid),
    .rd_ready_i (qu_ready),
    .rd_job_o   (qu_job)
  );

  jds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qu_valid),
    .in_ready_o  (qu_ready),
    .in_job_i    (qu_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .x_pos_o     (x_pos),
    .y_pos_o     (y_pos)
  );

  assign m_axis_tdata = {y_pos, x_pos};

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking stream testbench for joystick_deadzone_scaler_core with a scoreboard class.

// Scoreboard: mirrors the config registers, predicts each scaled pair and checks results.
class joy_scoreboard;
  typedef struct packed {
    logic [7:0] y_pos;
    logic [7:0] x_pos;
  } pos_t;

  logic [11:0] x_center;
  logic [11:0] y_center;
  logic [10:0] dead_band;
  logic [10:0] full_scale;
  pos_t        expected_pos[$];
  int unsigned mismatches;

  function new();
    x_center   = 12'd2047;
    y_center   = 12'd2047;
    dead_band  = 11'd200;
    full_scale = 11'd1700;
    mismatches = 0;
  endfunction

  function void write_reg(jds_pkg::cfg_idx_e idx, logic [11:0] value);
    case (idx)
      jds_pkg::CfgXCenter:   x_center = value;
      jds_pkg::CfgYCenter:   y_center = value;
      jds_pkg::CfgDeadBand:  dead_band = value[10:0];
      jds_pkg::CfgFullScale: full_scale = value[10:0];
      default: ;
    endcase
  endfunction

  // Offset, clamp, invert, dead zone, clamp to full scale, map onto -100..100.
  function logic [7:0] scaled_axis(logic [11:0] sample, logic [11:0] center);
    int v;
    int db;
    int fs;
    int m;
    db = int'(dead_band);
    fs = (full_scale == 11'd0) ? 1 : int'(full_scale);
    v  = int'(sample) - int'(center);
    if (v > 2000) v = 2000;
    if (v < -2000) v = -2000;
    v = -v;
    if (v > db) v = v - db;
    else if (v < -db) v = v + db;
    else v = 0;
    if (v > fs) v = fs;
    if (v < -fs) v = -fs;
    // v + fs is never negative here, so integer division is floor division
    m = ((v + fs) * 200) / (2 * fs) - 100;
    return m[7:0];
  endfunction

  function void note_sample(logic [11:0] x, logic [11:0] y);
    pos_t p;
    p.x_pos = scaled_axis(x, x_center);
    p.y_pos = scaled_axis(y, y_center);
    expected_pos.push_back(p);
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task check_position(logic [15:0] data);
    pos_t got;
    pos_t want;
    got = data;
    if (expected_pos.size() == 0) begin
      report($sformatf("result %h with no sample pending", data));
      return;
    end
    want = expected_pos.pop_front();
    if (got.x_pos !== want.x_pos)
      report($sformatf("x_pos got %0d, expected %0d",
                       $signed(got.x_pos), $signed(want.x_pos)));
    if (got.y_pos !== want.y_pos)
      report($sformatf("y_pos got %0d, expected %0d",
                       $signed(got.y_pos), $signed(want.y_pos)));
  endtask

  function int pending();
    return expected_pos.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline latency; used for the final drain only
  localparam int LATENCY         = 10;
  localparam int DRAIN_CYCLES    = 3 * LATENCY;
  // Watchdog limit on idle time between transactions
  localparam int IDLE_LIMIT      = 2000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int FIXED_PHASES    = 5;
  localparam int RANDOM_PHASES   = 6;
  localparam int DIRECTED_ITEMS  = 11;

  // Directed pairs at reset config (center 2047, dead band 200, full scale 1700):
  // rails, center, both dead-zone edges, both full-scale edges, both diff clamps
  localparam int DIR_X [DIRECTED_ITEMS] =
    '{0, 4095, 2047, 1847, 1846, 147, 146, 47, 46, 2048, 2};
  localparam int DIR_Y [DIRECTED_ITEMS] =
    '{4095, 0, 2047, 2247, 2248, 3947, 3948, 4047, 4048, 2046, 4093};

  // Extreme settings: zero dead band with full scale one, maximum legal values,
  // dead band above 2000 with full scale zero, full scale above 2000, and
  // register data with bit 11 set (dropped by the 11-bit registers)
  localparam int FIX_XC [FIXED_PHASES] = '{0, 4095, 2047, 1000, 2047};
  localparam int FIX_YC [FIXED_PHASES] = '{4095, 0, 2048, 3000, 2047};
  localparam int FIX_DB [FIXED_PHASES] = '{0, 2000, 2047, 0, 2198};
  localparam int FIX_FS [FIXED_PHASES] = '{1, 2000, 0, 2047, 3048};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // x_sample, y_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // x_pos, y_pos
  logic        cfg_we_i;
  jds_pkg::cfg_idx_e cfg_idx_i;
  logic [11:0] cfg_data_i;

  // Idle-free stretches on each side, flipped now and then
  bit tx_steady;
  bit rx_steady;

  joy_scoreboard sb;

  joystick_deadzone_scaler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // One register write; the block is idle whenever this runs
  task automatic put_reg(jds_pkg::cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[11:0];
    sb.write_reg(idx, value[11:0]);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic load_config(int xc, int yc, int db, int fs);
    put_reg(jds_pkg::CfgXCenter, xc);
    put_reg(jds_pkg::CfgYCenter, yc);
    put_reg(jds_pkg::CfgDeadBand, db);
    put_reg(jds_pkg::CfgFullScale, fs);
  endtask

  // Drive one sample pair; tvalid stays high only while the next pair follows at once
  task automatic send_pair(logic [11:0] x, logic [11:0] y);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_sample(x, y);
  endtask

  task automatic end_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Sample near a breakpoint of the transfer curve (center, dead-zone edge,
  // full-scale edge or diff clamp) or at a random offset, either side, a little jitter
  function automatic logic [11:0] near_point(logic [11:0] center);
    int base;
    int off;
    int v;
    int fs;
    fs = (sb.full_scale == 11'd0) ? 1 : int'(sb.full_scale);
    case ($urandom_range(0, 4))
      0:       base = 0;
      1:       base = int'(sb.dead_band);
      2:       base = int'(sb.dead_band) + fs;
      3:       base = 2000;
      default: base = $urandom_range(0, 2100);
    endcase
    off = base + $urandom_range(0, 4) - 2;
    if ($urandom_range(0, 1) == 1) off = -off;
    v = int'(center) + off;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic logic [11:0] pick_sample(logic [11:0] center);
    int r;
    if ($urandom_range(0, 1) == 1) begin
      r = $urandom_range(0, 4095);
      return r[11:0];
    end
    return near_point(center);
  endfunction

  // Result side: random back-pressure, every accepted transaction is checked
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_position(m_axis_tdata);
    end
  end

  // Watchdog: too many cycles without any transaction on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int xc;
    int yc;
    int db;
    int fs;
    int dx;
    int dy;
    logic [11:0] x;
    logic [11:0] y;
    sb            = new();
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = jds_pkg::CfgXCenter;
    cfg_data_i    = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs against the reset configuration
    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      dx = DIR_X[i];
      dy = DIR_Y[i];
      x  = dx[11:0];
      y  = dy[11:0];
      send_pair(x, y);
    end

    for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
      end_stream();
      wait_drained();
      if (p < FIXED_PHASES) begin
        xc = FIX_XC[p];
        yc = FIX_YC[p];
        db = FIX_DB[p];
        fs = FIX_FS[p];
      end else begin
        xc = $urandom_range(0, 4095);
        yc = $urandom_range(0, 4095);
        db = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
        fs = $urandom_range(1, 2047);
      end
      load_config(xc, yc, db, fs);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        x = pick_sample(sb.x_center);
        y = pick_sample(sb.y_center);
        send_pair(x, y);
      end
    end

    end_stream();
    wait_drained();
    // catch any stray result the block might still emit
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

// File: joystick_deadzone_scaler_core.f
src/jds_pkg.sv
src/jds_front.sv
src/jds_queue.sv
src/jds_back.sv
src/joystick_deadzone_scaler_core.sv
tb/sv/tb_top.sv
